// ----- rtl/bmrc_pkg.sv -----
// Shared types and constants for the bit map range set and count block.
package bmrc_pkg;

   localparam int MAX_BITS    = 4096;
   localparam int STORE_BYTES = (MAX_BITS + 7) / 8;
   localparam int IDX_W       = $clog2(MAX_BITS) + 1;
   localparam int ADDR_W      = $clog2(STORE_BYTES);
   localparam int POP_W       = 4;

   localparam logic [IDX_W-1:0] MAX_LEN = IDX_W'(MAX_BITS);

   typedef enum logic [1:0] {
      REQ_SET    = 2'd0,
      REQ_TEST   = 2'd1,
      REQ_COUNT  = 2'd2,
      REQ_RESIZE = 2'd3
   } bmrc_code_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_TEST,
      ST_DRAIN,
      ST_RESP
   } bmrc_state_type;

   typedef struct packed {
      bmrc_code_type    req_type;
      logic [IDX_W-1:0] begin_index;
      logic [IDX_W-1:0] end_index;
      logic             bit_value;
   } bmrc_req_type;

   typedef struct packed {
      logic             bit_read;
      logic [IDX_W-1:0] bit_count;
      logic             bad_request;
   } bmrc_rsp_type;

   // Per-byte control handed to the byte unit.
   typedef struct packed {
      logic [2:0] lo_bit;
      logic [2:0] hi_bit;
      logic       fill;
   } bmrc_byte_ctl_type;

endpackage

// ----- rtl/bmrc_byte_unit.sv -----
// Byte unit: range mask, masked merge and masked popcount for one byte.
module bmrc_byte_unit
   import bmrc_pkg::*;
(
   input  logic [7:0]        byte_in,
   input  bmrc_byte_ctl_type ctl,
   output logic [7:0]        byte_out,
   output logic [POP_W-1:0]  ones
);

   logic [7:0] mask;
   logic [7:0] hit;

   assign mask = (8'hff << ctl.lo_bit) & (8'hff >> (3'd7 - ctl.hi_bit));
   assign hit  = byte_in & mask;
   assign byte_out = ctl.fill ? (byte_in | mask) : (byte_in & ~mask);

   always_comb begin
      ones = '0;
      for (int i = 0; i < 8; i++) begin
         ones = ones + POP_W'(hit[i]);
      end
   end

endmodule

// ----- rtl/bitmap_range_set_and_count.sv -----
// Top level: bit map with range fill, bit test, range count and resize.
//
// Usage: drive req_data and raise start; the transaction is taken on the
// clock edge where start is high and busy is low. busy stays high until the
// result has been presented. Exactly one result follows each transaction:
// rsp_valid pulses for one cycle with rsp_data, and the receiver cannot
// stall it, so it must capture the result on that cycle.
//
// Timing: set, count and resize walk the byte store with one read-modify-
// write (or one popcount) per byte, reads and writes overlapped on the
// store's separate read and write ports. Test reads a single byte; an empty
// range or a bad request goes straight to the result. The next transaction
// can start the cycle after rsp_valid.
//
// Reset: synchronous, active high. The length returns to zero; the byte
// store is not cleared, since every bit below the length is written by a
// resize fill or set before it can be read.
module bitmap_range_set_and_count
   import bmrc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  bmrc_req_type req_data,
   output logic         busy,
   output logic         rsp_valid,
   output bmrc_rsp_type rsp_data
);

   bmrc_state_type state_ff, state_in;

   // byte store, one read and one write port
   logic [7:0] store_mem [STORE_BYTES];

   logic [IDX_W-1:0]  length_ff;
   bmrc_code_type     op_ff;
   logic              val_ff;
   logic [IDX_W-1:0]  begin_ff;
   logic [IDX_W-1:0]  end_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [ADDR_W-1:0] last_ff;
   logic [2:0]        last_bit_ff;
   logic [ADDR_W-1:0] rd_addr_ff;
   logic              rd_valid_ff;
   logic [7:0]        rdata_ff;
   logic [IDX_W-1:0]  count_ff;
   logic              bad_ff;
   logic              bit_ff;

   logic              accept;
   logic              rd_en;
   logic [IDX_W-1:0]  clamp_end;
   logic [IDX_W-1:0]  new_len;
   logic [IDX_W-1:0]  rng_lo;
   logic [IDX_W-1:0]  rng_hi;
   logic [IDX_W-1:0]  rng_hi_m1;
   logic              walk_go;
   logic              bad_now;
   logic [IDX_W-1:0]  span;

   bmrc_byte_ctl_type byte_ctl;
   logic [7:0]        byte_merged;
   logic [POP_W-1:0]  byte_ones;

   assign accept = start && !busy;

   // request decode: clamp ranges against the current length (resize against capacity)
   always_comb begin
      clamp_end = (req_data.end_index > length_ff) ? length_ff : req_data.end_index;
      new_len   = (req_data.end_index > MAX_LEN) ? MAX_LEN : req_data.end_index;
      rng_lo    = req_data.begin_index;
      rng_hi    = clamp_end;
      walk_go   = 1'b0;
      bad_now   = 1'b0;
      case (req_data.req_type)
         REQ_SET: begin
            walk_go = req_data.begin_index < clamp_end;
         end
         REQ_TEST: begin
            bad_now = req_data.begin_index >= length_ff;
         end
         REQ_COUNT: begin
            bad_now = req_data.begin_index > clamp_end;
            walk_go = req_data.begin_index < clamp_end;
         end
         REQ_RESIZE: begin
            rng_lo  = length_ff;
            rng_hi  = new_len;
            walk_go = new_len > length_ff;
         end
         default: begin
            walk_go = 1'b0;
         end
      endcase
      rng_hi_m1 = rng_hi - IDX_W'(1);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.req_type == REQ_TEST && !bad_now) begin
                  state_in = ST_TEST;
               end else if (walk_go) begin
                  state_in = ST_WALK;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_WALK: begin
            if (addr_ff == last_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_TEST:  state_in = ST_DRAIN;
         ST_DRAIN: state_in = ST_RESP;
         ST_RESP:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      busy      = state_ff != ST_IDLE;
      rd_en     = (state_ff == ST_WALK) || (state_ff == ST_TEST);
      rsp_valid = state_ff == ST_RESP;
   end

   // per-byte mask: partial at the first and last bytes of the range
   always_comb begin
      byte_ctl.lo_bit = (rd_addr_ff == begin_ff[ADDR_W+2:3]) ? begin_ff[2:0] : 3'd0;
      byte_ctl.hi_bit = (rd_addr_ff == last_ff) ? last_bit_ff : 3'd7;
      byte_ctl.fill   = val_ff;
   end

   bmrc_byte_unit u_byte (
      .byte_in  (rdata_ff),
      .ctl      (byte_ctl),
      .byte_out (byte_merged),
      .ones     (byte_ones)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         length_ff   <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_valid_ff <= rd_en;
         if (accept && req_data.req_type == REQ_RESIZE) begin
            length_ff <= new_len;
         end
      end
   end

   // transaction registers
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff       <= req_data.req_type;
         val_ff      <= req_data.bit_value;
         begin_ff    <= rng_lo;
         end_ff      <= rng_hi;
         addr_ff     <= rng_lo[ADDR_W+2:3];
         last_ff     <= rng_hi_m1[ADDR_W+2:3];
         last_bit_ff <= rng_hi_m1[2:0];
         count_ff    <= '0;
         bad_ff      <= bad_now;
         bit_ff      <= 1'b0;
      end else begin
         if (state_ff == ST_WALK && addr_ff != last_ff) begin
            addr_ff <= addr_ff + ADDR_W'(1);
         end
         if (rd_valid_ff) begin
            if (op_ff == REQ_TEST) begin
               bit_ff <= rdata_ff[begin_ff[2:0]];
            end else if (op_ff == REQ_COUNT) begin
               count_ff <= count_ff + IDX_W'(byte_ones);
            end
         end
      end
   end

   // byte store: read one byte ahead while writing back the previous one
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff   <= store_mem[addr_ff];
         rd_addr_ff <= addr_ff;
      end
      if (rd_valid_ff && (op_ff == REQ_SET || op_ff == REQ_RESIZE)) begin
         store_mem[rd_addr_ff] <= byte_merged;
      end
   end

   assign span = end_ff - begin_ff;

   always_comb begin
      rsp_data.bit_read    = bit_ff;
      rsp_data.bad_request = bad_ff;
      rsp_data.bit_count   = '0;
      if (op_ff == REQ_COUNT && !bad_ff) begin
         rsp_data.bit_count = val_ff ? count_ff : (span - count_ff);
      end
   end

   a_strobe_one_cycle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("transaction taken without going busy");

   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (addr_ff <= last_ff))
      else $error("byte walk ran past the last byte");

   a_test_single_read: assert property (@(posedge clock) disable iff (reset)
      (rd_valid_ff && op_ff == REQ_TEST) |-> (state_ff == ST_DRAIN))
      else $error("test read returned outside drain");

   a_bad_is_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.bad_request) |->
         (!rsp_data.bit_read && rsp_data.bit_count == '0))
      else $error("bad request reported with nonzero data");

endmodule

// ----- bench/tb_bitmap_range_set_and_count.sv -----
// Self-checking bench for the bit map range set / test / count / resize block.
module tb_bitmap_range_set_and_count;
   import bmrc_pkg::*;

   // Run shape. Every transaction yields exactly one result, so the random
   // part stops after a fixed number of transactions.
   localparam int N_RANDOM     = 1125;
   localparam int CALM_TAIL    = 150;   // last transactions sent back to back
   localparam int STALL_LIMIT  = 4000;  // well above the worst gap: a full-map walk plus the longest idle burst
   localparam int DRAIN_CYCLES = 600;   // past the longest latency after the last result
   localparam int MAX_REPORTS  = 10;

   // One row of the directed table. When has_rsp is set the expected result
   // is the one typed in the row; otherwise the shadow map supplies it.
   typedef struct packed {
      bmrc_req_type req;
      logic         has_rsp;
      bmrc_rsp_type rsp;
   } directed_case_type;

   logic         clock = 1'b0;
   logic         reset;
   logic         start;
   bmrc_req_type req_data;
   logic         busy;
   logic         rsp_valid;
   bmrc_rsp_type rsp_data;

   // Shadow copy of the block: one entry per bit plus the current length.
   // Entries are only ever read below the length, where they have been written.
   logic              shadow_bits [MAX_BITS];
   int                shadow_len;
   bmrc_rsp_type      pending_rsp_q [$];
   int                mismatches;
   int                idle_pct;
   int                stall_cycles;
   directed_case_type directed_cases [26];

   bitmap_range_set_and_count DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // 8-unit clock period.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Apply one request to the shadow map and return the result it should give.
   function automatic bmrc_rsp_type apply_to_shadow(bmrc_req_type r);
      bmrc_rsp_type res;
      int lo;
      int hi;
      int ones;
      int new_len;
      res  = '0;
      lo   = int'(r.begin_index);
      hi   = int'(r.end_index);
      ones = 0;
      case (r.req_type)
         REQ_SET: begin
            // end clamps to the length; an empty or reversed range is a no-op
            if (hi > shadow_len) hi = shadow_len;
            for (int i = lo; i < hi; i++) shadow_bits[i] = r.bit_value;
         end
         REQ_TEST: begin
            if (lo >= shadow_len) res.bad_request = 1'b1;
            else res.bit_read = shadow_bits[lo];
         end
         REQ_COUNT: begin
            if (hi > shadow_len) hi = shadow_len;
            if (lo > hi) begin
               res.bad_request = 1'b1;
            end else begin
               for (int i = lo; i < hi; i++) if (shadow_bits[i]) ones++;
               res.bit_count = IDX_W'(r.bit_value ? ones : (hi - lo) - ones);
            end
         end
         default: begin
            // resize: saturate at capacity; only a grow writes the fill value,
            // and it rewrites whatever a past shrink left behind
            new_len = (hi > MAX_BITS) ? MAX_BITS : hi;
            for (int i = shadow_len; i < new_len; i++) shadow_bits[i] = r.bit_value;
            shadow_len = new_len;
         end
      endcase
      return res;
   endfunction

   function automatic directed_case_type dir_case(bmrc_code_type code, int lo, int hi,
                                                  bit v, bit has_rsp, bit rd, int cnt,
                                                  bit bad);
      directed_case_type c;
      c.req.req_type    = code;
      c.req.begin_index = IDX_W'(lo);
      c.req.end_index   = IDX_W'(hi);
      c.req.bit_value   = v;
      c.has_rsp         = has_rsp;
      c.rsp.bit_read    = rd;
      c.rsp.bit_count   = IDX_W'(cnt);
      c.rsp.bad_request = bad;
      return c;
   endfunction

   // Random request. Most are well formed against the current length so that
   // fills and counts hit real data; the rest use raw 13-bit indices.
   function automatic bmrc_req_type random_request();
      bmrc_req_type r;
      int pick;
      int size_pick;
      int lo;
      int hi;
      pick        = $urandom_range(0, 99);
      r.bit_value = 1'($urandom_range(0, 1));
      lo          = $urandom_range(0, 8191);
      hi          = $urandom_range(0, 8191);
      if (pick < 14) begin
         r.req_type = REQ_RESIZE;
         // mostly short maps keep the walks short; a few full or past capacity
         size_pick = $urandom_range(0, 99);
         if (size_pick < 60) hi = $urandom_range(0, 320);
         else if (size_pick < 85) hi = $urandom_range(0, MAX_BITS);
         else if (size_pick < 90) hi = MAX_BITS;
         else if (size_pick < 94) hi = 0;
         // remaining few keep the raw value, often past capacity
      end else begin
         if (pick < 44) r.req_type = REQ_SET;
         else if (pick < 69) r.req_type = REQ_TEST;
         else r.req_type = REQ_COUNT;
         if ($urandom_range(0, 99) < 85) begin
            if (r.req_type == REQ_TEST) begin
               lo = (shadow_len > 0) ? $urandom_range(0, shadow_len - 1) : 0;
            end else begin
               lo = $urandom_range(0, shadow_len);
               hi = $urandom_range(lo, shadow_len);
            end
         end
      end
      r.begin_index = IDX_W'(lo);
      r.end_index   = IDX_W'(hi);
      return r;
   endfunction

   // Drive one transaction, hold it until start && !busy at an edge, then
   // record its expected result. An optional idle burst follows; start stays
   // high otherwise so back-to-back transactions get no extra assignment.
   task automatic issue(bmrc_req_type r, logic has_rsp, bmrc_rsp_type typed_rsp,
                        bit may_idle);
      bmrc_rsp_type predicted;
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      predicted = apply_to_shadow(r);
      pending_rsp_q.push_back(has_rsp ? typed_rsp : predicted);
      if (may_idle && $urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
   endtask

   // Result checker: results cannot be held off, so every strobe is taken
   // at the edge that ends its cycle and matched to the oldest expectation.
   always @(posedge clock) begin : check_results
      bmrc_rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_rsp_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected result: rd=%0d cnt=%0d bad=%0d",
                        rsp_data.bit_read, rsp_data.bit_count, rsp_data.bad_request);
         end else begin
            want = pending_rsp_q.pop_front();
            if (rsp_data.bit_read !== want.bit_read ||
                rsp_data.bit_count !== want.bit_count ||
                rsp_data.bad_request !== want.bad_request) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display({"result mismatch: expected rd=%0d cnt=%0d bad=%0d,",
                            " got rd=%0d cnt=%0d bad=%0d"},
                           want.bit_read, want.bit_count, want.bad_request,
                           rsp_data.bit_read, rsp_data.bit_count, rsp_data.bad_request);
            end
         end
      end
   end

   // Watchdog: any accepted transaction or result restarts the count.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("[bitmap_range_set_and_count] ERROR");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      reset      = 1'b1;
      start      = 1'b0;
      req_data   = '0;
      shadow_len = 0;
      mismatches = 0;
      idle_pct   = 35;
      stall_cycles = 0;

      // Directed table. Rows 0-17 start from reset and have results typed in
      // the row; later rows mostly leave the result to the shadow map.
      directed_cases = '{
         // empty map: test is out of range, count of nothing, reversed count
         dir_case(REQ_TEST,      0,    0, 1'b0, 1'b1, 1'b0,    0, 1'b1),
         dir_case(REQ_COUNT,     0,    0, 1'b1, 1'b1, 1'b0,    0, 1'b0),
         dir_case(REQ_COUNT,     5,   10, 1'b0, 1'b1, 1'b0,    0, 1'b1),
         // set past length clamps to an empty range
         dir_case(REQ_SET,       0,  100, 1'b1, 1'b1, 1'b0,    0, 1'b0),
         // resize past capacity saturates; whole map filled with ones
         dir_case(REQ_RESIZE, 8191, 8191, 1'b1, 1'b1, 1'b0,    0, 1'b0),
         dir_case(REQ_COUNT,     0, 4096, 1'b1, 1'b1, 1'b0, 4096, 1'b0),
         dir_case(REQ_COUNT,     0, 8191, 1'b0, 1'b1, 1'b0,    0, 1'b0),
         dir_case(REQ_TEST,   4095,    0, 1'b0, 1'b1, 1'b1,    0, 1'b0),
         dir_case(REQ_TEST,   4096,    0, 1'b1, 1'b1, 1'b0,    0, 1'b1),
         dir_case(REQ_TEST,   8191, 8191, 1'b0, 1'b1, 1'b0,    0, 1'b1),
         // clear everything, count zeros over the full map
         dir_case(REQ_SET,       0, 8191, 1'b0, 1'b1, 1'b0,    0, 1'b0),
         dir_case(REQ_COUNT,     0, 4096, 1'b0, 1'b1, 1'b0, 4096, 1'b0),
         // shrink to nothing, grow back: stale zeros are rewritten as ones
         dir_case(REQ_RESIZE,    0,    0, 1'b1, 1'b1, 1'b0,    0, 1'b0),
         dir_case(REQ_RESIZE,    0, 4096, 1'b1, 1'b1, 1'b0,    0, 1'b0),
         dir_case(REQ_COUNT,  4096, 4096, 1'b1, 1'b1, 1'b0,    0, 1'b0),
         dir_case(REQ_COUNT,  4097, 8191, 1'b1, 1'b1, 1'b0,    0, 1'b1),
         dir_case(REQ_RESIZE,    0,  100, 1'b0, 1'b1, 1'b0,    0, 1'b0),
         dir_case(REQ_RESIZE,    0, 1000, 1'b0, 1'b1, 1'b0,    0, 1'b0),
         // partial bytes, aligned byte, empty reversed set, reversed count, begin past length
         dir_case(REQ_COUNT,     0, 1000, 1'b1, 1'b0, 1'b0,    0, 1'b0),
         dir_case(REQ_SET,       3,   13, 1'b0, 1'b0, 1'b0,    0, 1'b0),
         dir_case(REQ_COUNT,     0,   16, 1'b1, 1'b0, 1'b0,    0, 1'b0),
         dir_case(REQ_SET,       8,   16, 1'b1, 1'b0, 1'b0,    0, 1'b0),
         dir_case(REQ_SET,      20,   19, 1'b1, 1'b0, 1'b0,    0, 1'b0),
         dir_case(REQ_COUNT,    50,   40, 1'b1, 1'b1, 1'b0,    0, 1'b1),
         dir_case(REQ_TEST,     12,    0, 1'b0, 1'b0, 1'b0,    0, 1'b0),
         dir_case(REQ_SET,    7000, 8191, 1'b1, 1'b0, 1'b0,    0, 1'b0)
      };

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_cases[n])
         issue(directed_cases[n].req, directed_cases[n].has_rsp, directed_cases[n].rsp, 1'b1);

      // Random part. The idle rate changes every hundred transactions so
      // there are busy stretches, sparse ones and runs with no gaps; the
      // tail goes back to back.
      for (int k = 0; k < N_RANDOM; k++) begin
         if (k % 100 == 0) begin
            case ($urandom_range(0, 2))
               0:       idle_pct = 0;
               1:       idle_pct = 20;
               default: idle_pct = 60;
            endcase
         end
         issue(random_request(), 1'b0, '0, k < N_RANDOM - CALM_TAIL);
      end
      start <= 1'b0;

      // Drain: the watchdog catches a result that never comes.
      while (pending_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && pending_rsp_q.size() == 0)
         $display("[bitmap_range_set_and_count] OK");
      else
         $display("[bitmap_range_set_and_count] ERROR");
      $finish;
   end

endmodule
